### hw/rtl/rsdp_pkg.sv
// Shared constants, types and codes of the root pointer signature scanner.
`timescale 1ns / 1ps
`default_nettype none

package rsdp_pkg;

	// Scan geometry
	localparam int ALIGN_STEP = 16;
	localparam int OFF_W      = $clog2(ALIGN_STEP);
	localparam int SIG_LEN    = 8;
	localparam int SIG_IDX_W  = $clog2(SIG_LEN);
	localparam int V1_SUM_LEN = 20;

	// Signature "RSD PTR ", first byte at index 0
	localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
		8'h52, 8'h53, 8'h44, 8'h20, 8'h50, 8'h54, 8'h52, 8'h20
	};

	// Byte positions inside the structure
	localparam int IDX_W = 32;
	localparam logic [IDX_W-1:0] IDX_SIG_END    = IDX_W'(SIG_LEN);
	localparam logic [IDX_W-1:0] IDX_REVISION   = IDX_W'(15);
	localparam logic [IDX_W-1:0] IDX_SADDR_LO   = IDX_W'(16);
	localparam logic [IDX_W-1:0] IDX_SADDR_HI   = IDX_W'(19);
	localparam logic [IDX_W-1:0] IDX_LEN_LO     = IDX_W'(20);
	localparam logic [IDX_W-1:0] IDX_LEN_HI     = IDX_W'(23);
	localparam logic [IDX_W-1:0] IDX_XADDR_LO   = IDX_W'(24);
	localparam logic [IDX_W-1:0] IDX_XADDR_HI   = IDX_W'(31);
	localparam logic [IDX_W-1:0] IDX_V1_LAST    = IDX_W'(V1_SUM_LEN - 1);
	localparam logic [IDX_W-1:0] IDX_V1_END     = IDX_W'(V1_SUM_LEN);
	localparam logic [IDX_W-1:0] MIN_V2_LEN     = IDX_W'(24);

	// Result queue depth
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		ST_NOT_FOUND = 2'd0,
		ST_FOUND     = 2'd1,
		ST_BAD_SUM   = 2'd2
	} status_t;

	// Raw result as left by the scanner, formatted later
	typedef struct packed {
		status_t     status;
		logic        rev_nz;
		logic [31:0] short_addr;
		logic [63:0] long_addr;
	} rsdp_rec_t;

	// Queue occupancy seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

### hw/rtl/rsdp_in_if.sv
// Byte stream channel: one region byte per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface rsdp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/rsdp_out_if.sv
// Result channel: one search outcome per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface rsdp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] location;
	logic        is_xsdt;

	modport source (output valid, output status, output location, output is_xsdt, input ready);
	modport sink   (input valid, input status, input location, input is_xsdt, output ready);
endinterface

`default_nettype wire

### hw/rtl/acpi_rsdp_scanner.sv
// Top level of the root system description pointer scanner.
//
// Usage:
//   byte_ch   - sink: one byte of the searched region per transaction, in
//               address order, last_byte set on the final byte.
//   result_ch - source: exactly one transaction per region: status
//               (not found, found, checksum failed), location and is_xsdt.
//   A signature is tried at every 16-byte offset counted from the region
//   start. After a result, remaining bytes are consumed until last_byte.
// Throughput: one byte per cycle while the queue is not full; the per-byte
//   compare, add and 33-bit length compare in the front end sets that figure.
// Result path: the byte that decides a result writes it into the queue, from
//   where it is loaded into the output register.
// Reset: arst_n clears all scan state and empties queue and output stage.
// Stall: results wait in a two-entry queue plus the output register;
//   byte_ch.ready drops only while the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module acpi_rsdp_scanner (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rsdp_in_if.sink     byte_ch,
	rsdp_out_if.source  result_ch
);
	import rsdp_pkg::*;

	logic      push;
	logic      pop;
	rsdp_rec_t wr_rec;
	rsdp_rec_t rd_rec;
	q_stat_t   qstat;

	rsdp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.qstat  (qstat),
		.push   (push),
		.rec    (wr_rec)
	);

	rsdp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.qstat  (qstat)
	);

	rsdp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_rec   (rd_rec),
		.qstat    (qstat),
		.pop      (pop),
		.result_ch(result_ch)
	);

endmodule

`default_nettype wire

### hw/rtl/rsdp_front.sv
// Scanner front end: signature match, field capture, checksum and result decision.
`timescale 1ns / 1ps
`default_nettype none

module rsdp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rsdp_in_if.sink                 byte_ch,
	input  rsdp_pkg::q_stat_t       qstat,
	output logic                    push,
	output rsdp_pkg::rsdp_rec_t     rec
);
	import rsdp_pkg::*;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_STRUCT = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [OFF_W-1:0]   off_q, off_d;
	logic               sig_match_q, sig_match_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [7:0]         sum_q, sum_d;
	logic [7:0]         rev_q, rev_d;
	logic [31:0]        saddr_q, saddr_d;
	logic [31:0]        len_q, len_d;
	logic [63:0]        xaddr_q, xaddr_d;

	logic               accept;
	logic               done;
	status_t            st;
	logic [IDX_W:0]     idx_inc;
	logic [7:0]         b;

	assign byte_ch.ready = !qstat.full;
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign b             = byte_ch.data_byte;
	assign idx_inc       = {1'b0, idx_q} + (IDX_W+1)'(1);

	// Per-byte next state
	always_comb begin
		phase_d     = phase_q;
		off_d       = off_q;
		sig_match_d = sig_match_q;
		idx_d       = idx_q;
		sum_d       = sum_q;
		rev_d       = rev_q;
		saddr_d     = saddr_q;
		len_d       = len_q;
		xaddr_d     = xaddr_q;
		done        = 1'b0;
		st          = ST_NOT_FOUND;
		push        = 1'b0;

		if (accept) begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (off_q < OFF_W'(SIG_LEN)) begin
						if (off_q == '0) begin
							sig_match_d = 1'b1;
							sum_d       = b;
						end else begin
							sum_d = sum_q + b;
						end
						if (b != SIG_BYTES[off_q[SIG_IDX_W-1:0]])
							sig_match_d = 1'b0;
					end
					if (off_q == OFF_W'(SIG_LEN - 1) && sig_match_d) begin
						phase_d = PH_STRUCT;
						idx_d   = IDX_SIG_END;
						off_d   = '0;
						rev_d   = '0;
						saddr_d = '0;
						len_d   = '0;
						xaddr_d = '0;
					end else if (off_q == OFF_W'(ALIGN_STEP - 1)) begin
						off_d = '0;
					end else begin
						off_d = off_q + OFF_W'(1);
					end
				end
				PH_STRUCT: begin
					// field capture, little endian
					if (idx_q == IDX_REVISION)
						rev_d = b;
					else if (idx_q >= IDX_SADDR_LO && idx_q <= IDX_SADDR_HI)
						saddr_d[8*idx_q[1:0] +: 8] = b;
					else if (idx_q >= IDX_LEN_LO && idx_q <= IDX_LEN_HI)
						len_d[8*idx_q[1:0] +: 8] = b;
					else if (idx_q >= IDX_XADDR_LO && idx_q <= IDX_XADDR_HI)
						xaddr_d[8*idx_q[2:0] +: 8] = b;

					if (rev_d == '0) begin
						if (idx_q < IDX_V1_END)
							sum_d = sum_q + b;
						if (idx_q == IDX_V1_LAST) begin
							done = 1'b1;
							st   = (sum_d == '0) ? ST_FOUND : ST_BAD_SUM;
						end
					end else begin
						if (idx_q <= IDX_LEN_HI || idx_q < len_d)
							sum_d = sum_q + b;
						if (idx_q == IDX_LEN_HI && len_d < MIN_V2_LEN) begin
							done = 1'b1;
							st   = ST_BAD_SUM;
						end else if (idx_q >= IDX_XADDR_HI && idx_inc >= {1'b0, len_d}) begin
							done = 1'b1;
							st   = (sum_d == '0) ? ST_FOUND : ST_BAD_SUM;
						end
					end

					if (done) begin
						phase_d = PH_DONE;
						push    = 1'b1;
					end else begin
						idx_d = idx_inc[IDX_W-1:0];
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase

			// end of region: report a miss if nothing was reported, then restart
			if (byte_ch.last_byte) begin
				if (!done && phase_q != PH_DONE)
					push = 1'b1;
				phase_d     = PH_SEARCH;
				off_d       = '0;
				sig_match_d = 1'b1;
				idx_d       = '0;
				sum_d       = '0;
				rev_d       = '0;
				saddr_d     = '0;
				len_d       = '0;
				xaddr_d     = '0;
			end
		end
	end

	// Result record toward the queue
	always_comb begin
		rec            = '0;
		rec.status     = done ? st : ST_NOT_FOUND;
		rec.rev_nz     = (rev_q != '0) || (phase_q == PH_STRUCT && idx_q == IDX_REVISION && b != '0);
		rec.short_addr = saddr_q;
		rec.long_addr  = xaddr_q;
		if (phase_q == PH_STRUCT) begin
			if (idx_q >= IDX_SADDR_LO && idx_q <= IDX_SADDR_HI)
				rec.short_addr[8*idx_q[1:0] +: 8] = b;
			else if (idx_q >= IDX_XADDR_LO && idx_q <= IDX_XADDR_HI)
				rec.long_addr[8*idx_q[2:0] +: 8] = b;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEARCH;
			off_q       <= '0;
			sig_match_q <= 1'b1;
			idx_q       <= '0;
			sum_q       <= '0;
			rev_q       <= '0;
			saddr_q     <= '0;
			len_q       <= '0;
			xaddr_q     <= '0;
		end else begin
			phase_q     <= phase_d;
			off_q       <= off_d;
			sig_match_q <= sig_match_d;
			idx_q       <= idx_d;
			sum_q       <= sum_d;
			rev_q       <= rev_d;
			saddr_q     <= saddr_d;
			len_q       <= len_d;
			xaddr_q     <= xaddr_d;
		end
	end

`ifndef SYNTHESIS
	// a result only leaves with an accepted byte, and never into a full queue
	a_push_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (accept && !qstat.full))
		else $error("result pushed without an accepted byte");

	// while searching, only a miss can be reported
	a_search_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(push && phase_q == PH_SEARCH) |-> (rec.status == ST_NOT_FOUND))
		else $error("hit reported while still searching");

	// the last byte always returns the scanner to the start of a region
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_ch.last_byte) |=> (phase_q == PH_SEARCH && off_q == '0 && idx_q == '0))
		else $error("scanner not restarted after region end");

	// structure walk always starts past the signature
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STRUCT) |-> (idx_q >= IDX_SIG_END))
		else $error("structure index below signature end");
`endif

endmodule

`default_nettype wire

### hw/rtl/rsdp_queue.sv
// Two-entry result queue between scanner front end and output stage.
`timescale 1ns / 1ps
`default_nettype none

module rsdp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  rsdp_pkg::rsdp_rec_t     wr_rec,
	input  wire logic               pop,
	output rsdp_pkg::rsdp_rec_t     rd_rec,
	output rsdp_pkg::q_stat_t       qstat
);
	import rsdp_pkg::*;

	rsdp_rec_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_rec      = mem_q[rd_ptr_q];

	// Storage, written at the tail
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

### hw/rtl/rsdp_back.sv
// Output stage: formats queued results and holds them until taken.
`timescale 1ns / 1ps
`default_nettype none

module rsdp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  rsdp_pkg::rsdp_rec_t     rd_rec,
	input  rsdp_pkg::q_stat_t       qstat,
	output logic                    pop,
	rsdp_out_if.source              result_ch
);
	import rsdp_pkg::*;

	logic        valid_q;
	logic [1:0]  status_q;
	logic [63:0] location_q;
	logic        is_xsdt_q;
	logic [63:0] loc_d;

	assign pop = !qstat.empty && (!valid_q || result_ch.ready);

	// Address choice by revision; zero unless the checksum passed
	always_comb begin
		loc_d = '0;
		if (rd_rec.status == ST_FOUND)
			loc_d = rd_rec.rev_nz ? rd_rec.long_addr : {32'b0, rd_rec.short_addr};
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (result_ch.ready)
			valid_q <= 1'b0;
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q   <= rd_rec.status;
			location_q <= loc_d;
			is_xsdt_q  <= (rd_rec.status != ST_NOT_FOUND) && rd_rec.rev_nz;
		end
	end

	assign result_ch.valid    = valid_q;
	assign result_ch.status   = status_q;
	assign result_ch.location = location_q;
	assign result_ch.is_xsdt  = is_xsdt_q;

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for acpi_rsdp_scanner: directed and random regions against a byte predictor.
`timescale 1ns / 1ps

module testbench;
	import rsdp_pkg::*;

	localparam int RANDOM_BYTES = 1170;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 11;

	typedef enum int {
		SCAN_SEARCH,
		SCAN_STRUCT,
		SCAN_DONE
	} scan_phase_t;

	typedef struct {
		status_t     status;
		logic [63:0] location;
		logic        is_xsdt;
	} outcome_t;

	logic clk;
	logic arst_n;

	rsdp_in_if  byte_if ();
	rsdp_out_if result_if ();

	acpi_rsdp_scanner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_if),
		.result_ch (result_if)
	);

	// Scanner shadow state
	scan_phase_t scan_phase;
	int          scan_offset;
	logic        sig_hit;
	logic [31:0] struct_pos;
	logic [7:0]  run_sum;
	logic [7:0]  rev_byte;
	logic [31:0] addr32;
	logic [31:0] tbl_len;
	logic [63:0] addr64;

	outcome_t   expected_outcomes[$];
	logic [7:0] region_bytes[$];
	int         bytes_sent;
	int         bad_results;
	int         cycle_count;
	bit         no_idle;

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result sink with random stalls
	always @(posedge clk) begin
		result_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Result checker
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_outcomes.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result: status %0d location %h is_xsdt %0d",
						result_if.status, result_if.location, result_if.is_xsdt);
			end else begin
				want = expected_outcomes.pop_front();
				if (result_if.status !== want.status || result_if.location !== want.location ||
						result_if.is_xsdt !== want.is_xsdt) begin
					bad_results++;
					if (bad_results <= 10)
						$display({"mismatch: expected status %0d location %h is_xsdt %0d,",
							" got status %0d location %h is_xsdt %0d"},
							want.status, want.location, want.is_xsdt,
							result_if.status, result_if.location, result_if.is_xsdt);
				end
			end
		end
	end

	task automatic clear_scan();
		scan_phase  = SCAN_SEARCH;
		scan_offset = 0;
		sig_hit     = 1'b1;
		struct_pos  = '0;
		run_sum     = '0;
		rev_byte    = '0;
		addr32      = '0;
		tbl_len     = '0;
		addr64      = '0;
	endtask

	task automatic push_outcome(input status_t st);
		outcome_t o;
		o.status   = st;
		o.location = '0;
		o.is_xsdt  = (st != ST_NOT_FOUND) && (rev_byte != 8'd0);
		if (st == ST_FOUND)
			o.location = (rev_byte == 8'd0) ? {32'd0, addr32} : addr64;
		expected_outcomes.push_back(o);
	endtask

	// Advance the shadow scanner by one accepted byte
	task automatic scan_byte(input logic [7:0] b, input bit last);
		bit          matched;
		bit          done;
		bit          emitted;
		status_t     st;
		logic [31:0] pos;
		matched = 1'b0;
		done    = 1'b0;
		emitted = 1'b0;
		st      = ST_NOT_FOUND;
		case (scan_phase)
			SCAN_SEARCH: begin
				// signature compare on the first bytes of each 16-byte block
				if (scan_offset < SIG_LEN) begin
					if (scan_offset == 0) begin
						sig_hit = 1'b1;
						run_sum = '0;
					end
					if (b != SIG_BYTES[scan_offset])
						sig_hit = 1'b0;
					run_sum += b;
					if (scan_offset == SIG_LEN - 1 && sig_hit)
						matched = 1'b1;
				end
				if (matched) begin
					scan_phase  = SCAN_STRUCT;
					struct_pos  = SIG_LEN;
					scan_offset = 0;
					rev_byte    = '0;
					addr32      = '0;
					tbl_len     = '0;
					addr64      = '0;
				end else begin
					scan_offset = (scan_offset == ALIGN_STEP - 1) ? 0 : scan_offset + 1;
				end
			end
			SCAN_STRUCT: begin
				pos = struct_pos;
				// field capture, little endian
				if (pos == 32'd15)
					rev_byte = b;
				else if (pos >= 32'd16 && pos <= 32'd19)
					addr32[8*(pos-16) +: 8] = b;
				else if (pos >= 32'd20 && pos <= 32'd23)
					tbl_len[8*(pos-20) +: 8] = b;
				else if (pos >= 32'd24 && pos <= 32'd31)
					addr64[8*(pos-24) +: 8] = b;
				// checksum and end of structure
				if (rev_byte == 8'd0) begin
					if (pos < V1_SUM_LEN)
						run_sum += b;
					if (pos == V1_SUM_LEN - 1) begin
						done = 1'b1;
						st   = (run_sum == 8'd0) ? ST_FOUND : ST_BAD_SUM;
					end
				end else begin
					if (pos < 32'd24 || pos < tbl_len)
						run_sum += b;
					if (pos == 32'd23 && tbl_len < 32'd24) begin
						done = 1'b1;
						st   = ST_BAD_SUM;
					end else if (pos >= 32'd31 && (33'(pos) + 33'd1) >= 33'(tbl_len)) begin
						done = 1'b1;
						st   = (run_sum == 8'd0) ? ST_FOUND : ST_BAD_SUM;
					end
				end
				if (done) begin
					push_outcome(st);
					emitted    = 1'b1;
					scan_phase = SCAN_DONE;
				end else begin
					struct_pos = pos + 32'd1;
				end
			end
			default: ;
		endcase
		// region end: report not found unless a result already went out
		if (last) begin
			if (!emitted && scan_phase != SCAN_DONE)
				push_outcome(ST_NOT_FOUND);
			clear_scan();
		end
	endtask

	// Send one byte transaction, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input bit last);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			byte_if.valid <= 1'b0;
			@(posedge clk);
		end
		byte_if.valid     <= 1'b1;
		byte_if.data_byte <= b;
		byte_if.last_byte <= last;
		do
			@(posedge clk);
		while (!byte_if.ready);
		scan_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_region();
		foreach (region_bytes[i])
			send_byte(region_bytes[i], i == region_bytes.size() - 1);
		region_bytes.delete();
	endtask

	task automatic add_junk(input int n);
		repeat (n) region_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Append a pointer structure; the checksum byte is set so the sum is zero when good
	task automatic add_rsdp(input logic [7:0] rev, input logic [31:0] a32,
			input logic [31:0] len, input logic [63:0] a64, input bit good);
		logic [7:0] s[$];
		logic [7:0] acc;
		int         span;
		int         sum_end;
		for (int i = 0; i < SIG_LEN; i++)
			s.push_back(SIG_BYTES[i]);
		s.push_back(8'h00);
		repeat (6) s.push_back(8'($urandom_range(0, 255)));
		s.push_back(rev);
		for (int i = 0; i < 4; i++)
			s.push_back(a32[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			s.push_back(len[8*i +: 8]);
		for (int i = 0; i < 8; i++)
			s.push_back(a64[8*i +: 8]);
		span = 32;
		if (rev != 8'd0 && len > 32'd32 && len <= 32'd512)
			span = len;
		while (s.size() < span)
			s.push_back(8'($urandom_range(0, 255)));
		if (rev == 8'd0) begin
			while (s.size() > V1_SUM_LEN)
				void'(s.pop_back());
			sum_end = V1_SUM_LEN;
		end else if (len < 32'd24) begin
			sum_end = 24;
		end else begin
			sum_end = (len > span) ? span : len;
		end
		acc = '0;
		for (int i = 0; i < sum_end; i++)
			acc += s[i];
		s[8] = 8'd0 - acc;
		if (!good)
			s[8] += 8'($urandom_range(1, 255));
		foreach (s[i])
			region_bytes.push_back(s[i]);
	endtask

	// Regions of one byte and a region ending on the signature match
	task automatic test_tiny_regions();
		region_bytes.push_back(8'h00);
		send_region();
		region_bytes.push_back(8'hFF);
		send_region();
		for (int i = 0; i < SIG_LEN; i++)
			region_bytes.push_back(SIG_BYTES[i]);
		send_region();
	endtask

	// Revision zero: 20-byte sum
	task automatic test_rev0();
		// result on the last byte of the region
		add_rsdp(8'd0, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b1);
		send_region();
		// zero address still counts as found
		add_rsdp(8'd0, 32'd0, 32'd0, 64'd0, 1'b1);
		add_junk(5);
		send_region();
		add_rsdp(8'd0, $urandom(), 32'd0, 64'd0, 1'b0);
		add_junk(3);
		send_region();
	endtask

	// Later revisions: length-driven sum, 64-bit address
	task automatic test_later_revisions();
		add_rsdp(8'd2, $urandom(), 32'd36, '1, 1'b1);
		add_junk(2);
		send_region();
		// length under 32: result waits for byte 31
		add_rsdp(8'd1, $urandom(), 32'd24, 64'd0, 1'b1);
		send_region();
		// short lengths fail the checksum
		add_rsdp(8'hFF, $urandom(), 32'd23, {$urandom(), $urandom()}, 1'b1);
		add_junk(1);
		send_region();
		add_rsdp(8'd2, $urandom(), 32'd0, {$urandom(), $urandom()}, 1'b1);
		send_region();
		add_rsdp(8'd2, $urandom(), 32'd40, {$urandom(), $urandom()}, 1'b0);
		send_region();
		add_rsdp(8'd2, $urandom(), 32'd255, {$urandom(), $urandom()}, 1'b1);
		send_region();
	endtask

	// Alignment, cut-off structures and bytes after a result
	task automatic test_search_rules();
		add_rsdp(8'd2, $urandom(), 32'd36, {$urandom(), $urandom()}, 1'b1);
		repeat (10) void'(region_bytes.pop_back());
		send_region();
		// signature off the 16-byte grid
		add_junk(4);
		add_rsdp(8'd0, $urandom(), 32'd0, 64'd0, 1'b1);
		send_region();
		// near miss at offset 0, real structure at offset 16
		for (int i = 0; i < SIG_LEN - 1; i++)
			region_bytes.push_back(SIG_BYTES[i]);
		region_bytes.push_back(8'h58);
		add_junk(8);
		add_rsdp(8'd0, $urandom(), 32'd0, 64'd0, 1'b1);
		send_region();
		// a second structure after a result is ignored
		add_rsdp(8'd0, $urandom(), 32'd0, 64'd0, 1'b1);
		add_junk(12);
		add_rsdp(8'd2, $urandom(), 32'd36, {$urandom(), $urandom()}, 1'b1);
		send_region();
	endtask

	// One random region: mostly well-formed structures, some broken ones and noise
	task automatic random_region();
		int          kind;
		int          pick;
		int          base;
		int          keep;
		logic [7:0]  rev;
		logic [31:0] len;
		logic [31:0] a32;
		logic [63:0] a64;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 3);
		rev  = (pick == 3) ? 8'($urandom_range(1, 255)) : 8'(pick);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = $urandom_range(24, 48);
		else if (pick < 80)
			len = $urandom_range(49, 255);
		else if (pick < 90)
			len = $urandom_range(0, 23);
		else
			len = $urandom_range(32, 40);
		a32 = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
		a64 = ($urandom_range(0, 19) == 0) ? 64'd0 : {$urandom(), $urandom()};
		if (kind < 75) begin
			add_junk(16 * $urandom_range(0, 2));
			add_rsdp(rev, a32, len, a64, kind < 60);
			add_junk($urandom_range(0, 6));
		end else if (kind < 85) begin
			// structure cut off by the region end
			if (kind % 2 == 1 && rev != 8'd0)
				len = $urandom();
			add_junk(16 * $urandom_range(0, 1));
			base = region_bytes.size();
			add_rsdp(rev, a32, len, a64, 1'b1);
			keep = $urandom_range(1, region_bytes.size() - base - 1);
			while (region_bytes.size() > base + keep)
				void'(region_bytes.pop_back());
		end else if (kind < 93) begin
			if (kind % 2 == 0) begin
				add_junk(16 * $urandom_range(0, 1) + $urandom_range(1, 15));
				add_rsdp(rev, a32, len, a64, 1'b1);
			end else begin
				base = region_bytes.size();
				add_rsdp(rev, a32, len, a64, 1'b1);
				region_bytes[base + $urandom_range(0, SIG_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
			end
			add_junk($urandom_range(0, 6));
		end else begin
			add_junk($urandom_range(1, 48));
		end
		send_region();
	endtask

	task automatic test_random_regions();
		int start_count;
		start_count = bytes_sent;
		while (bytes_sent - start_count < RANDOM_BYTES) begin
			// middle third runs with no idling on either side
			no_idle = (bytes_sent - start_count >= RANDOM_BYTES / 3) &&
				(bytes_sent - start_count < 2 * RANDOM_BYTES / 3);
			random_region();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n              = 1'b0;
		byte_if.valid       = 1'b0;
		byte_if.data_byte   = '0;
		byte_if.last_byte   = 1'b0;
		result_if.ready     = 1'b0;
		bytes_sent          = 0;
		bad_results         = 0;
		cycle_count         = 0;
		no_idle             = 1'b0;
		clear_scan();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tiny_regions();
		test_rev0();
		test_later_revisions();
		test_search_rules();
		test_random_regions();
		byte_if.valid <= 1'b0;

		// drain outstanding results
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_results == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
